// ===== design/nfq_pkg.sv =====
// Shared widths, request and status codes for the nearest-first request queue.
package nfq_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int COORD_W  = 32;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;
  localparam int BUDGET_W = 7;
  localparam int CFG_IDX_W = 1;

  // request types
  localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_OUT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP        = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PENDING     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_PENDING = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 1'd1;

endpackage

// ===== design/nfq_ifs.sv =====
// Channel interfaces: request, result and configuration write.
interface nfq_req_if import nfq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_z;
  logic                       already_done;
  logic [COORD_W-1:0]         radius;
  logic [BUDGET_W-1:0]        budget;

  modport source (output valid, req_type, pos_x, pos_z, already_done, radius, budget,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_z, already_done, radius, budget,
                  output ready);
endinterface

interface nfq_res_if import nfq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [CNT_W-1:0]           removed_count;
  logic                       popped_valid;
  logic signed [COORD_W-1:0]  popped_x;
  logic signed [COORD_W-1:0]  popped_z;
  logic                       more_pending;
  logic                       last;

  modport source (output valid, status, removed_count, popped_valid, popped_x, popped_z,
                  more_pending, last, input ready);
  modport sink   (input valid, status, removed_count, popped_valid, popped_x, popped_z,
                  more_pending, last, output ready);
endinterface

interface nfq_cfg_if import nfq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   idx;
  logic [COORD_W-1:0]     data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== design/nfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nfq_dist.sv =====
// Per-axis distance unit: absolute differences on x and z, each 33 bits wide.
module nfq_dist import nfq_pkg::*; (
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_z,
  output logic [COORD_W:0]          dx,
  output logic [COORD_W:0]          dz
);

  logic [COORD_W:0] diff_x;
  logic [COORD_W:0] diff_z;

  always_comb begin
    diff_x = {a_x[COORD_W-1], a_x} - {b_x[COORD_W-1], b_x};
    diff_z = {a_z[COORD_W-1], a_z} - {b_z[COORD_W-1], b_z};
    // magnitude tops out at 2**32 - 1, which fits unsigned in 33 bits
    dx = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
    dz = diff_z[COORD_W] ? (~diff_z + 1'b1) : diff_z;
  end

endmodule

// ===== design/nearest_first_request_queue_unit.sv =====
// Nearest-first request queue: pending coordinate table with insert/remove/prune/pop.
//
// Channels: req carries one request transaction (insert, remove, remove-outside, pop);
// res returns result transactions, the final one of each request marked by last;
// cfg writes center_x (index 0) and center_z (index 1), always ready; the user must
// write only while idle, which the block itself does not enforce. Timing: each
// request that scans reads the table one slot per cycle through the single read port
// of the coordinate RAM, with a two-stage compare pipeline behind it. Insert, remove
// and remove-outside make one full scan; a pop makes one full scan for each popped
// entry. Insert of an already-done coordinate, a zero-budget pop and a pop of an
// empty table answer without a scan. req is ready only when no request is in work.
// Results sit in an output register; a stalled receiver holds the sequencer at the
// point where the next result is due, and the table does not change meanwhile.
// Reset: synchronous, empties the table at once (per-slot used flags and occupancy
// clear), sets both centers to zero and drops any pending result. No clearing pass.
module nearest_first_request_queue_unit import nfq_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  nfq_cfg_if.sink   cfg,
  nfq_req_if.sink   req,
  nfq_res_if.source res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t state;

  // configuration
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_z;

  // table control state
  logic [TABLE_DEPTH-1:0] used;
  logic [CNT_W-1:0]       occ;

  // latched request
  logic [REQ_W-1:0]          op;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_z;
  logic                      done;
  logic [COORD_W-1:0]        radius;
  logic [BUDGET_W-1:0]       budget;
  logic [CNT_W-1:0]          pop_n;

  // scan pipeline
  logic              issue;
  logic [IDX_W-1:0]  addr;
  logic              p1_vld;
  logic [IDX_W-1:0]  p1_idx;
  logic              p2_vld;
  logic [IDX_W-1:0]  p2_idx;
  logic              p2_used;
  logic              p2_eq;
  logic [COORD_W:0]  p2_dx;
  logic [COORD_W:0]  p2_dz;
  logic signed [COORD_W-1:0] p2_x;
  logic signed [COORD_W-1:0] p2_z;

  // scan trackers
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  cnt;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [COORD_W+1:0] best_sum;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_z;

  // result register
  logic                      res_valid;
  logic [STATUS_W-1:0]       res_status;
  logic [CNT_W-1:0]          res_count;
  logic                      res_pv;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_z;
  logic                      res_more;
  logic                      res_last;

  // RAM and distance unit
  logic                       ram_we;
  logic [2*COORD_W-1:0]       ram_rdata;
  logic signed [COORD_W-1:0]  rd_x;
  logic signed [COORD_W-1:0]  rd_z;
  logic signed [COORD_W-1:0]  ref_x;
  logic signed [COORD_W-1:0]  ref_z;
  logic [COORD_W:0]           dx;
  logic [COORD_W:0]           dz;

  logic              req_acc;
  logic              out_free;
  logic [COORD_W+1:0] sum;
  logic              better;
  logic              far;
  logic [CNT_W-1:0]  remaining;
  logic              pop_cont;
  logic              take;
  logic [STATUS_W-1:0] emit_status;
  logic              emit_more;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !res_valid || res.ready;

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.removed_count = res_count;
  assign res.popped_valid  = res_pv;
  assign res.popped_x      = res_x;
  assign res.popped_z      = res_z;
  assign res.more_pending  = res_more;
  assign res.last          = res_last;

  assign ram_we = (state == S_EMIT) && out_free && (op == REQ_INSERT) && !done &&
                  !match_found && free_found;

  nfq_ram #(
    .WIDTH (2*COORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({pos_x, pos_z}),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign rd_x  = ram_rdata[2*COORD_W-1:COORD_W];
  assign rd_z  = ram_rdata[COORD_W-1:0];
  assign ref_x = (op == REQ_POP) ? center_x : pos_x;
  assign ref_z = (op == REQ_POP) ? center_z : pos_z;

  nfq_dist u_dist (
    .a_x (rd_x),
    .a_z (rd_z),
    .b_x (ref_x),
    .b_z (ref_z),
    .dx  (dx),
    .dz  (dz)
  );

  always_comb begin
    sum = {1'b0, p2_dx} + {1'b0, p2_dz};
    better = !best_found || (sum < best_sum) ||
             ((sum == best_sum) && ((p2_x < best_x) || ((p2_x == best_x) && (p2_z < best_z))));
    far = (p2_dx > {1'b0, radius}) || (p2_dz > {1'b0, radius});
    remaining = occ - CNT_W'(1);
    pop_cont = (remaining != '0) && (({1'b0, pop_n} + 8'd1) < {1'b0, budget});
    take = (op == REQ_POP) && best_found;

    case (op)
      REQ_INSERT: begin
        if (done) begin
          emit_status = ST_DONE;
        end else if (match_found) begin
          emit_status = ST_PENDING;
        end else if (free_found) begin
          emit_status = ST_OK;
        end else begin
          emit_status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        emit_status = match_found ? ST_OK : ST_NOT_PENDING;
      end
      default: begin
        emit_status = ST_OK;
      end
    endcase

    if (op != REQ_POP) begin
      emit_more = 1'b0;
    end else if (!best_found) begin
      // nothing taken: zero budget or empty table
      emit_more = (occ != '0);
    end else begin
      emit_more = !pop_cont && (remaining != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      center_x  <= '0;
      center_z  <= '0;
      used      <= '0;
      occ       <= '0;
      issue     <= 1'b0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.idx)
          REG_CENTER_X: center_x <= cfg.data;
          REG_CENTER_Z: center_z <= cfg.data;
        endcase
      end

      // emit reloads the result register itself
      if (res_valid && res.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end

      // scan pipeline: address -> RAM data + distances -> decision
      p1_vld <= issue;
      p1_idx <= addr;
      if (issue) begin
        addr <= addr + 1'b1;
        if (addr == LAST_IDX) begin
          issue <= 1'b0;
        end
      end
      p2_vld  <= p1_vld;
      p2_idx  <= p1_idx;
      p2_used <= used[p1_idx];
      p2_eq   <= (rd_x == pos_x) && (rd_z == pos_z);
      p2_dx   <= dx;
      p2_dz   <= dz;
      p2_x    <= rd_x;
      p2_z    <= rd_z;

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            op          <= req.req_type;
            pos_x       <= req.pos_x;
            pos_z       <= req.pos_z;
            done        <= req.already_done;
            radius      <= req.radius;
            budget      <= req.budget;
            pop_n       <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            best_found  <= 1'b0;
            cnt         <= '0;
            addr        <= '0;
            if ((req.req_type == REQ_INSERT && req.already_done) ||
                (req.req_type == REQ_POP && (req.budget == '0 || occ == '0))) begin
              state <= S_EMIT;
            end else begin
              issue <= 1'b1;
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (p2_vld) begin
            case (op)
              REQ_INSERT, REQ_REMOVE: begin
                if (p2_used && p2_eq && !match_found) begin
                  match_found <= 1'b1;
                  match_idx   <= p2_idx;
                end
                if (!p2_used && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= p2_idx;
                end
              end
              REQ_REMOVE_OUT: begin
                if (p2_used && far) begin
                  used[p2_idx] <= 1'b0;
                  occ          <= occ - CNT_W'(1);
                  cnt          <= cnt + CNT_W'(1);
                end
              end
              default: begin
                if (p2_used && better) begin
                  best_found <= 1'b1;
                  best_idx   <= p2_idx;
                  best_sum   <= sum;
                  best_x     <= p2_x;
                  best_z     <= p2_z;
                end
              end
            endcase
            if (p2_idx == LAST_IDX) begin
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_status <= emit_status;
            res_count  <= (op == REQ_REMOVE_OUT) ? cnt : '0;
            res_pv     <= take;
            res_x      <= take ? best_x : '0;
            res_z      <= take ? best_z : '0;
            res_more   <= emit_more;
            res_last   <= !(take && pop_cont);
            if (take && pop_cont) begin
              best_found <= 1'b0;
              addr       <= '0;
              issue      <= 1'b1;
              state      <= S_SCAN;
            end else begin
              state      <= S_IDLE;
            end
            case (op)
              REQ_INSERT: begin
                if (!done && !match_found && free_found) begin
                  used[free_idx] <= 1'b1;
                  occ            <= occ + CNT_W'(1);
                end
              end
              REQ_REMOVE: begin
                if (match_found) begin
                  used[match_idx] <= 1'b0;
                  occ             <= occ - CNT_W'(1);
                end
              end
              REQ_POP: begin
                if (best_found) begin
                  used[best_idx] <= 1'b0;
                  occ            <= remaining;
                  pop_n          <= pop_n + CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_matches_used: assert property (@(posedge clk) disable iff (rst)
    occ == CNT_W'($countones(used)))
    else $error("occupancy does not match the number of used slots");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_multi_only_pop: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> res_pv)
    else $error("non-final result that carries no popped coordinate");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req.ready)
    else $error("request accepted while previous one still in work");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the nearest-first request queue unit.
`timescale 1ns / 1ps

module testbench;
  import nfq_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic [COORD_W-1:0] RADIUS_ALL = 32'hffff_ffff;
  localparam logic [BUDGET_W-1:0] BUDGET_TOP = 7'd127;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit [REQ_W-1:0]           kind;
    bit signed [COORD_W-1:0]  x;
    bit signed [COORD_W-1:0]  z;
    bit                       done;
    bit [COORD_W-1:0]         radius;
    bit [BUDGET_W-1:0]        budget;
  } request_t;

  typedef struct {
    bit [STATUS_W-1:0]        status;
    bit [CNT_W-1:0]           removed;
    bit                       taken;
    bit signed [COORD_W-1:0]  px;
    bit signed [COORD_W-1:0]  pz;
    bit                       more;
    bit                       is_last;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  nfq_cfg_if cfg_ch ();
  nfq_req_if req_ch ();
  nfq_res_if res_ch ();

  nearest_first_request_queue_unit uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // Predicted table contents and priority center
  bit signed [COORD_W-1:0] ent_x [TABLE_DEPTH];
  bit signed [COORD_W-1:0] ent_z [TABLE_DEPTH];
  bit                      ent_live [TABLE_DEPTH];
  int                      live_count = 0;
  bit signed [COORD_W-1:0] hub_x = '0;
  bit signed [COORD_W-1:0] hub_z = '0;

  reply_t reply_backlog [$];
  int     mismatch_total = 0;
  logic   hold_replies = 1'b0;
  logic   steady = 1'b0;

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 14);
  endfunction

  // appends one expected result at the tail of the backlog
  function automatic void add_reply(reply_t rp);
    reply_backlog.insert(reply_backlog.size(), rp);
  endfunction

  function automatic longint span(bit signed [COORD_W-1:0] a, bit signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic int find_entry(bit signed [COORD_W-1:0] x, bit signed [COORD_W-1:0] z);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (ent_live[i] && ent_x[i] == x && ent_z[i] == z) return i;
    return -1;
  endfunction

  // nearest to the center first, then smaller x, then smaller z
  function automatic bit ahead_of(int a, int b);
    longint da, db;
    da = span(ent_x[a], hub_x) + span(ent_z[a], hub_z);
    db = span(ent_x[b], hub_x) + span(ent_z[b], hub_z);
    if (da != db) return da < db;
    if (ent_x[a] != ent_x[b]) return ent_x[a] < ent_x[b];
    return ent_z[a] < ent_z[b];
  endfunction

  function automatic void work_request(request_t r);
    reply_t rp;
    int     slot;
    int     n;
    int     best;
    longint keep;
    rp = '{default: 0};
    rp.is_last = 1'b1;
    case (r.kind)
      REQ_INSERT: begin
        if (r.done) begin
          rp.status = ST_DONE;
        end else if (find_entry(r.x, r.z) >= 0) begin
          rp.status = ST_PENDING;
        end else begin
          rp.status = ST_FULL;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!ent_live[i]) begin
              ent_live[i] = 1'b1;
              ent_x[i] = r.x;
              ent_z[i] = r.z;
              live_count++;
              rp.status = ST_OK;
              break;
            end
          end
        end
        add_reply(rp);
      end
      REQ_REMOVE: begin
        slot = find_entry(r.x, r.z);
        if (slot >= 0) begin
          ent_live[slot] = 1'b0;
          live_count--;
          rp.status = ST_OK;
        end else begin
          rp.status = ST_NOT_PENDING;
        end
        add_reply(rp);
      end
      REQ_REMOVE_OUT: begin
        keep = longint'({32'd0, r.radius});
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (ent_live[i] && (span(ent_x[i], r.x) > keep || span(ent_z[i], r.z) > keep)) begin
            ent_live[i] = 1'b0;
            live_count--;
            n++;
          end
        end
        rp.status = ST_OK;
        rp.removed = n[CNT_W-1:0];
        add_reply(rp);
      end
      default: begin
        n = 0;
        while (live_count > 0 && n < int'(r.budget) && n < TABLE_DEPTH) begin
          best = -1;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (ent_live[i] && (best < 0 || ahead_of(i, best))) best = i;
          ent_live[best] = 1'b0;
          live_count--;
          rp = '{default: 0};
          rp.status = ST_OK;
          rp.taken = 1'b1;
          rp.px = ent_x[best];
          rp.pz = ent_z[best];
          rp.is_last = (live_count == 0) || (n + 1 >= int'(r.budget)) || (n + 1 >= TABLE_DEPTH);
          rp.more = rp.is_last && (live_count != 0);
          add_reply(rp);
          n++;
        end
        if (n == 0) begin
          rp.status = ST_OK;
          rp.more = (live_count != 0);
          add_reply(rp);
        end
      end
    endcase
  endfunction

  function automatic request_t mk(bit [REQ_W-1:0] kind, bit signed [COORD_W-1:0] x,
                                  bit signed [COORD_W-1:0] z, bit done,
                                  bit [COORD_W-1:0] radius, bit [BUDGET_W-1:0] budget);
    request_t r;
    r.kind = kind;
    r.x = x;
    r.z = z;
    r.done = done;
    r.radius = radius;
    r.budget = budget;
    return r;
  endfunction

  function automatic bit pick_listed(output bit signed [COORD_W-1:0] x,
                                     output bit signed [COORD_W-1:0] z);
    int start;
    int k;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    x = '0;
    z = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      k = (start + i) % TABLE_DEPTH;
      if (ent_live[k]) begin
        x = ent_x[k];
        z = ent_z[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // mostly a small window around the base so that hits and ties are common
  function automatic bit signed [COORD_W-1:0] near_coord(bit signed [COORD_W-1:0] base);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return base + (int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic request_t random_request(bit signed [COORD_W-1:0] bx,
                                              bit signed [COORD_W-1:0] bz);
    request_t r;
    int roll;
    int pick;
    bit signed [COORD_W-1:0] hx, hz;
    r = mk(REQ_INSERT, near_coord(bx), near_coord(bz), 1'b0, '0, '0);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r = mk(REQ_W'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom_range(0, 1)),
             $urandom, BUDGET_W'($urandom_range(0, 127)));
    end else if (roll < 50) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) r.done = 1'b1;
      else if (pick < 5 && pick_listed(hx, hz)) begin
        r.x = hx;
        r.z = hz;
        r.done = (pick == 4);
      end
    end else if (roll < 70) begin
      r.kind = REQ_REMOVE;
      if ($urandom_range(0, 3) != 0 && pick_listed(hx, hz)) begin
        r.x = hx;
        r.z = hz;
      end
    end else if (roll < 78) begin
      r.kind = REQ_REMOVE_OUT;
      r.radius = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 12);
    end else begin
      r.kind = REQ_POP;
      pick = $urandom_range(0, 19);
      if (pick == 0) r.budget = '0;
      else if (pick < 3) r.budget = BUDGET_W'($urandom_range(0, 127));
      else if (pick < 6) r.budget = BUDGET_W'($urandom_range(0, 16));
      else r.budget = BUDGET_W'($urandom_range(1, 4));
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    while (take_break()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.pos_x <= r.x;
    req_ch.pos_z <= r.z;
    req_ch.already_done <= r.done;
    req_ch.radius <= r.radius;
    req_ch.budget <= r.budget;
    do @(posedge clk); while (!req_ch.ready);
    work_request(r);
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (reply_backlog.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // both center registers back to back; only called with the block idle
  task automatic set_center(bit signed [COORD_W-1:0] x, bit signed [COORD_W-1:0] z);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= REG_CENTER_X;
    cfg_ch.data <= x;
    do @(posedge clk); while (!cfg_ch.ready);
    hub_x = x;
    cfg_ch.idx <= REG_CENTER_Z;
    cfg_ch.data <= z;
    do @(posedge clk); while (!cfg_ch.ready);
    hub_z = z;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_mix(int count, bit signed [COORD_W-1:0] bx, bit signed [COORD_W-1:0] bz);
    for (int i = 0; i < count; i++) send_request(random_request(bx, bz));
  endtask

  task automatic test_basic_ops();
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, 7'd5));
    send_request(mk(REQ_INSERT, 0, 0, 1'b1, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MIN, COORD_MIN, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MAX, COORD_MAX, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MIN, COORD_MAX, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MAX, COORD_MIN, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MAX, COORD_MAX, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MAX, COORD_MAX, 1'b1, '0, '0));
    send_request(mk(REQ_REMOVE, 5, 5, 1'b0, '0, '0));
    send_request(mk(REQ_REMOVE, COORD_MIN, COORD_MAX, 1'b0, '0, '0));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, '0));
    // largest per-axis distance still fits an all-ones radius
    send_request(mk(REQ_REMOVE_OUT, COORD_MIN, COORD_MIN, 1'b0, RADIUS_ALL, '0));
    send_request(mk(REQ_REMOVE_OUT, COORD_MIN, COORD_MIN, 1'b0, '0, '0));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, BUDGET_TOP));
  endtask

  task automatic test_tie_order();
    drain_replies();
    send_request(mk(REQ_INSERT, 1, 0, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, 0, 1, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, -1, 0, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, 0, -1, 1'b0, '0, '0));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, 7'd2));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, 7'd64));
  endtask

  task automatic test_far_center();
    drain_replies();
    set_center(COORD_MIN, COORD_MAX);
    send_request(mk(REQ_INSERT, COORD_MAX, COORD_MIN, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, COORD_MIN, COORD_MAX, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, 0, 0, 1'b0, '0, '0));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, 7'd3));
  endtask

  task automatic test_mix_small_center();
    bit signed [COORD_W-1:0] cx, cz;
    drain_replies();
    cx = int'($urandom_range(0, 40)) - 20;
    cz = int'($urandom_range(0, 40)) - 20;
    set_center(cx, cz);
    run_mix(100, cx, cz);
  endtask

  task automatic test_mix_steady_corner();
    drain_replies();
    set_center(COORD_MAX, COORD_MIN);
    steady <= 1'b1;
    run_mix(90, COORD_MAX, COORD_MIN);
    drain_replies();
    steady <= 1'b0;
  endtask

  task automatic test_table_full();
    bit signed [COORD_W-1:0] hx, hz;
    drain_replies();
    set_center($urandom, $urandom);
    while (live_count < TABLE_DEPTH) send_request(mk(REQ_INSERT, $urandom, $urandom, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, $urandom, $urandom, 1'b0, '0, '0));
    if (pick_listed(hx, hz)) send_request(mk(REQ_INSERT, hx, hz, 1'b0, '0, '0));
    send_request(mk(REQ_INSERT, $urandom, $urandom, 1'b1, '0, '0));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, BUDGET_TOP));
    send_request(mk(REQ_POP, 0, 0, 1'b0, '0, 7'd3));
  endtask

  task automatic test_backpressure();
    drain_replies();
    fork
      begin
        hold_replies <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_replies <= 1'b0;
      end
    join_none
    run_mix(15, hub_x, hub_z);
  endtask

  task automatic test_mix_random_center();
    bit signed [COORD_W-1:0] cx, cz;
    drain_replies();
    cx = $urandom;
    cz = $urandom;
    set_center(cx, cz);
    run_mix(100, cx, cz);
  endtask

  task automatic test_mix_far_center();
    drain_replies();
    set_center(COORD_MIN, COORD_MAX);
    run_mix(60, COORD_MIN, COORD_MAX);
  endtask

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    res_ch.ready <= !hold_replies && !take_break();
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (reply_backlog.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual status %h x %h z %h",
                 $time, res_ch.status, res_ch.popped_x, res_ch.popped_z);
        mismatch_total++;
      end else begin
        want = reply_backlog.pop_front();
        check_field("status", want.status, res_ch.status);
        check_field("removed_count", want.removed, res_ch.removed_count);
        check_field("popped_valid", want.taken, res_ch.popped_valid);
        check_field("popped_x", want.px, res_ch.popped_x);
        check_field("popped_z", want.pz, res_ch.popped_z);
        check_field("more_pending", want.more, res_ch.more_pending);
        check_field("last", want.is_last, res_ch.last);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ent_live[i] = 1'b0;
      ent_x[i] = '0;
      ent_z[i] = '0;
    end
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx <= REG_CENTER_X;
    cfg_ch.data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.pos_x <= '0;
    req_ch.pos_z <= '0;
    req_ch.already_done <= 1'b0;
    req_ch.radius <= '0;
    req_ch.budget <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_tie_order();
    test_far_center();
    test_mix_small_center();
    test_mix_steady_corner();
    test_table_full();
    test_backpressure();
    test_mix_random_center();
    test_mix_far_center();

    drain_replies();
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nfq_pkg.sv
design/nfq_ifs.sv
design/nfq_ram.sv
design/nfq_dist.sv
design/nearest_first_request_queue_unit.sv
sim/testbench.sv
